/* rtl/core/bmhq_pkg.sv */
// ----------------------------------------------------------------------------
// bmhq_pkg: shared types and codes for the binary max-heap queue
// Key type, operation and status codes, memory control group.
// ----------------------------------------------------------------------------
package bmhq_pkg;

	localparam int KEY_W        = 32;
	localparam int CAPACITY_DEF = 64;

	typedef logic signed [KEY_W-1:0] key_t;

	localparam logic [2:0] FN_INSERT  = 3'd0;
	localparam logic [2:0] FN_EXTRACT = 3'd1;
	localparam logic [2:0] FN_CHANGE  = 3'd2;
	localparam logic [2:0] FN_REMOVE  = 3'd3;
	localparam logic [2:0] FN_PEEK    = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_INDEX = 2'd3;

	typedef struct packed {
		logic wr;
		logic rd_a;
		logic rd_b;
	} ram_ctl_t;

endpackage

/* rtl/core/binary_max_heap_queue_top.sv */
// ----------------------------------------------------------------------------
// binary_max_heap_queue_top: binary max-heap priority queue
// Insert, extract max, change key, remove at index and peek over a heap held
// in one memory, walked by a small sequencer around a shared comparator.
//
//   channel | handshake           | payload
//   --------+---------------------+----------------------------------
//   cmd     | cmd_valid/cmd_stall | func, key_value, slot_index
//   res     | res_valid/res_stall | out_key, status, entry_count
//
// One beat in, one beat out. Sift-up reads the parent and compares per level,
// sift-down reads both children and makes two compares through the comparator
// per level, and remove first bubbles the entry to the root; the carried key
// then lands in its slot, around a decode, memory fetch and result load.
// A rejected or spare beat goes straight from decode to the result load.
// Reset clears the fill count and the sequencer; memory contents are left.
// cmd_stall is high from accept until the result is loaded; a stalled result
// holds the last step until res_stall drops.
// ----------------------------------------------------------------------------
module binary_max_heap_queue_top #(
	parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_stall,
	input  logic [2:0]                      func,
	input  bmhq_pkg::key_t                  key_value,
	input  logic [$clog2(CAPACITY)-1:0]     slot_index,
	output logic                            res_valid,
	input  logic                            res_stall,
	output bmhq_pkg::key_t                  out_key,
	output logic [1:0]                      status,
	output logic [$clog2(CAPACITY+1)-1:0]   entry_count
);
	import bmhq_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CW    = IDX_W + 2;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_SU_RD   = 4'd1;
	localparam logic [3:0] S_SU_CMP  = 4'd2;
	localparam logic [3:0] S_SD_RD   = 4'd3;
	localparam logic [3:0] S_SD_CL   = 4'd4;
	localparam logic [3:0] S_SD_CR   = 4'd5;
	localparam logic [3:0] S_EX_GET  = 4'd6;
	localparam logic [3:0] S_CHG     = 4'd7;
	localparam logic [3:0] S_RB_RD   = 4'd8;
	localparam logic [3:0] S_RB_WR   = 4'd9;
	localparam logic [3:0] S_RM_LAST = 4'd10;
	localparam logic [3:0] S_RM_GET  = 4'd11;
	localparam logic [3:0] S_PK      = 4'd12;
	localparam logic [3:0] S_FIN     = 4'd13;

	logic [3:0]       state_q;
	logic [CNT_W-1:0] fill_q;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] best_q;
	key_t             key_q;
	key_t             bval_q;
	key_t             res_key_q;
	logic [1:0]       res_status_q;
	logic             res_valid_q;
	key_t             out_key_q;
	logic [1:0]       status_q;
	logic [CNT_W-1:0] count_q;

	ram_ctl_t         ram_ctl;
	logic [IDX_W-1:0] waddr;
	key_t             wdata;
	logic [IDX_W-1:0] raddr_a;
	logic [IDX_W-1:0] raddr_b;
	key_t             rda;
	key_t             rdb;

	key_t             cmp_a;
	key_t             cmp_b;
	logic             gt;

	logic             cmd_acc;
	logic [IDX_W-1:0] up_idx;
	logic [IDX_W-1:0] last_idx;
	logic [CW-1:0]    l_idx;
	logic [CW-1:0]    r_idx;
	logic [CW-1:0]    fill_ext;
	logic             l_ok;
	logic             r_ok;
	logic             pick_r;
	logic [IDX_W-1:0] best_idx;
	key_t             best_val;
	logic             empty;
	logic             slot_bad;

	assign cmd_stall   = (state_q != S_IDLE);
	assign cmd_acc     = cmd_valid && !cmd_stall;
	assign res_valid   = res_valid_q;
	assign out_key     = out_key_q;
	assign status      = status_q;
	assign entry_count = count_q;

	assign up_idx   = (pos_q - IDX_W'(1)) >> 1;
	assign last_idx = IDX_W'(fill_q - CNT_W'(1));
	assign l_idx    = {1'b0, pos_q, 1'b1};
	assign r_idx    = l_idx + CW'(1);
	assign fill_ext = CW'(fill_q);
	assign l_ok     = (l_idx < fill_ext);
	assign r_ok     = (r_idx < fill_ext);
	assign empty    = (fill_q == '0);
	assign slot_bad = (CNT_W'(slot_index) >= fill_q);

	// second child compare: take the right child only when it beats the best so far
	assign pick_r   = r_ok && gt;
	assign best_idx = pick_r ? r_idx[IDX_W-1:0] : best_q;
	assign best_val = pick_r ? rdb : bval_q;

	bmhq_cmp u_cmp (
		.a  (cmp_a),
		.b  (cmp_b),
		.gt (gt)
	);

	bmhq_ram #(
		.DEPTH (CAPACITY),
		.AW    (IDX_W)
	) u_ram (
		.clk     (clk),
		.ctl     (ram_ctl),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rda),
		.rdata_b (rdb)
	);

	always_comb begin
		cmp_a = key_q;
		cmp_b = rda;
		case (state_q)
			S_SD_CL: begin
				cmp_a = rda;
				cmp_b = key_q;
			end
			S_SD_CR: begin
				cmp_a = rdb;
				cmp_b = bval_q;
			end
			default: begin
				cmp_a = key_q;
				cmp_b = rda;
			end
		endcase
	end

	always_comb begin
		ram_ctl = '0;
		waddr   = pos_q;
		wdata   = key_q;
		raddr_a = '0;
		raddr_b = '0;
		case (state_q)
			S_IDLE: begin
				if (cmd_acc) begin
					case (func)
						FN_EXTRACT: begin
							ram_ctl.rd_a = !empty;
							ram_ctl.rd_b = !empty;
							raddr_b      = last_idx;
						end
						FN_CHANGE: begin
							ram_ctl.rd_a = !slot_bad;
							raddr_a      = slot_index;
						end
						FN_PEEK: begin
							ram_ctl.rd_a = !empty;
						end
						default: ;
					endcase
				end
			end
			S_SU_RD: begin
				if (pos_q == '0) begin
					ram_ctl.wr = 1'b1;
				end else begin
					ram_ctl.rd_a = 1'b1;
					raddr_a      = up_idx;
				end
			end
			S_SU_CMP: begin
				// parent drops into the hole, or the carried key lands here
				ram_ctl.wr = 1'b1;
				wdata      = gt ? rda : key_q;
			end
			S_SD_RD: begin
				if (!l_ok) begin
					ram_ctl.wr = 1'b1;
				end else begin
					ram_ctl.rd_a = 1'b1;
					ram_ctl.rd_b = 1'b1;
					raddr_a      = l_idx[IDX_W-1:0];
					raddr_b      = r_idx[IDX_W-1:0];
				end
			end
			S_SD_CR: begin
				ram_ctl.wr = 1'b1;
				wdata      = best_val;
			end
			S_RB_RD: begin
				ram_ctl.rd_a = 1'b1;
				raddr_a      = up_idx;
			end
			S_RB_WR: begin
				ram_ctl.wr = 1'b1;
				wdata      = rda;
			end
			S_RM_LAST: begin
				ram_ctl.rd_b = 1'b1;
				raddr_b      = last_idx;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			pos_q        <= '0;
			best_q       <= '0;
			key_q        <= '0;
			bval_q       <= '0;
			res_key_q    <= '0;
			res_status_q <= ST_OK;
			res_valid_q  <= 1'b0;
			out_key_q    <= '0;
			status_q     <= ST_OK;
			count_q      <= '0;
		end else begin
			if (res_valid_q && !res_stall && state_q != S_FIN) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						res_key_q <= '0;
						case (func)
							FN_INSERT: begin
								if (fill_q >= CNT_W'(CAPACITY)) begin
									res_status_q <= ST_FULL;
									state_q      <= S_FIN;
								end else begin
									res_status_q <= ST_OK;
									key_q        <= key_value;
									pos_q        <= IDX_W'(fill_q);
									fill_q       <= fill_q + CNT_W'(1);
									state_q      <= S_SU_RD;
								end
							end
							FN_EXTRACT: begin
								if (empty) begin
									res_status_q <= ST_EMPTY;
									state_q      <= S_FIN;
								end else begin
									res_status_q <= ST_OK;
									state_q      <= S_EX_GET;
								end
							end
							FN_CHANGE: begin
								if (slot_bad) begin
									res_status_q <= ST_INDEX;
									state_q      <= S_FIN;
								end else begin
									res_status_q <= ST_OK;
									key_q        <= key_value;
									pos_q        <= slot_index;
									state_q      <= S_CHG;
								end
							end
							FN_REMOVE: begin
								if (slot_bad) begin
									res_status_q <= ST_INDEX;
									state_q      <= S_FIN;
								end else begin
									res_status_q <= ST_OK;
									pos_q        <= slot_index;
									state_q      <= (slot_index == '0) ? S_RM_LAST : S_RB_RD;
								end
							end
							FN_PEEK: begin
								if (empty) begin
									res_status_q <= ST_EMPTY;
									state_q      <= S_FIN;
								end else begin
									res_status_q <= ST_OK;
									state_q      <= S_PK;
								end
							end
							default: begin
								res_status_q <= ST_OK;
								state_q      <= S_FIN;
							end
						endcase
					end
				end
				S_SU_RD: begin
					state_q <= (pos_q == '0) ? S_FIN : S_SU_CMP;
				end
				S_SU_CMP: begin
					if (gt) begin
						pos_q   <= up_idx;
						state_q <= S_SU_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_SD_RD: begin
					state_q <= l_ok ? S_SD_CL : S_FIN;
				end
				S_SD_CL: begin
					if (gt) begin
						best_q <= l_idx[IDX_W-1:0];
						bval_q <= rda;
					end else begin
						best_q <= pos_q;
						bval_q <= key_q;
					end
					state_q <= S_SD_CR;
				end
				S_SD_CR: begin
					if (best_idx == pos_q) begin
						state_q <= S_FIN;
					end else begin
						pos_q   <= best_idx;
						state_q <= S_SD_RD;
					end
				end
				S_EX_GET: begin
					// root goes out, last entry restarts the sift from the root
					res_key_q <= rda;
					key_q     <= rdb;
					fill_q    <= fill_q - CNT_W'(1);
					pos_q     <= '0;
					state_q   <= S_SD_RD;
				end
				S_CHG: begin
					state_q <= gt ? S_SU_RD : S_SD_RD;
				end
				S_RB_RD: begin
					state_q <= S_RB_WR;
				end
				S_RB_WR: begin
					pos_q   <= up_idx;
					state_q <= (up_idx == '0) ? S_RM_LAST : S_RB_RD;
				end
				S_RM_LAST: begin
					state_q <= S_RM_GET;
				end
				S_RM_GET: begin
					key_q   <= rdb;
					fill_q  <= fill_q - CNT_W'(1);
					pos_q   <= '0;
					state_q <= S_SD_RD;
				end
				S_PK: begin
					res_key_q <= rda;
					state_q   <= S_FIN;
				end
				S_FIN: begin
					// hold until the result register is free
					if (!res_valid_q || !res_stall) begin
						out_key_q   <= res_key_q;
						status_q    <= res_status_q;
						count_q     <= fill_q;
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(CAPACITY))
		else $error("fill count above capacity");

	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && (!res_valid_q || !res_stall)) |=>
			(res_valid_q && state_q == S_IDLE))
		else $error("result not loaded on finish");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status == ST_EMPTY) |-> (entry_count == '0))
		else $error("empty status with nonzero count");

	a_sift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SD_RD) |-> ((CNT_W'(pos_q) < fill_q) || (fill_q == '0)))
		else $error("sift-down position beyond fill count");

endmodule

/* rtl/core/bmhq_ram.sv */
// ----------------------------------------------------------------------------
// bmhq_ram: heap key storage
// One write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module bmhq_ram #(
	parameter int DEPTH = bmhq_pkg::CAPACITY_DEF,
	parameter int AW    = $clog2(bmhq_pkg::CAPACITY_DEF)
) (
	input  logic                clk,
	input  bmhq_pkg::ram_ctl_t  ctl,
	input  logic [AW-1:0]       waddr,
	input  bmhq_pkg::key_t      wdata,
	input  logic [AW-1:0]       raddr_a,
	input  logic [AW-1:0]       raddr_b,
	output bmhq_pkg::key_t      rdata_a,
	output bmhq_pkg::key_t      rdata_b
);
	import bmhq_pkg::*;

	key_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[waddr] <= wdata;
		end
	end

	// hold read data until the next read on that port
	always_ff @(posedge clk) begin
		if (ctl.rd_a) begin
			rdata_a <= mem[raddr_a];
		end
		if (ctl.rd_b) begin
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

/* rtl/core/bmhq_cmp.sv */
// ----------------------------------------------------------------------------
// bmhq_cmp: shared key comparator
// Signed two's complement greater-than, reused by every sift step.
// ----------------------------------------------------------------------------
module bmhq_cmp (
	input  bmhq_pkg::key_t a,
	input  bmhq_pkg::key_t b,
	output logic           gt
);
	import bmhq_pkg::*;

	assign gt = (a > b);

endmodule
